>>> hw/rtl/kslp_pkg.sv
// ----------------------------------------------------------------------------
// kslp_pkg
// Shared types and constants of the short/long key press classifier.
// ----------------------------------------------------------------------------
package kslp_pkg;

  // input command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_PRESS   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // press kinds
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
  localparam int          MAX_RESULTS      = 16;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] key_index;
  } kslp_in_t;

  typedef struct packed {
    logic       press_kind;
    logic [1:0] column;
    logic [1:0] row;
    logic       last_of_run;
  } kslp_out_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PRESS,
    OP_RELEASE
  } kslp_op_t;

  // decoded word passed from front to back
  typedef struct packed {
    kslp_op_t   op;
    logic [3:0] key;
  } kslp_cmd_t;

endpackage

>>> hw/rtl/key_short_long_press_classifier.sv
// ----------------------------------------------------------------------------
// key_short_long_press_classifier
// Classifies key presses on a key matrix as short or long.
// ----------------------------------------------------------------------------
//  channel   handshake          word           notes
//  input     push / full        in_word        tick, press or release
//  result    empty / pop        out_word       one word per detected press
//  config    cfg_write          cfg_data       long-press threshold, ms
//
//  Press: done in the back end's idle state. Release: idle, then a result
//  state. Tick: a scan reading one start time a cycle, unless a full result
//  queue stalls it, from the single port start-time memory, then a flush.
//  Reset clears timer, held flags and both queues; no clearing pass.
//  A full result queue stalls the scan, the flush or a release; the two-word
//  command queue then fills and raises full.
// ----------------------------------------------------------------------------
module key_short_long_press_classifier import kslp_pkg::*; #(
  parameter int NUM_KEYS    = 16,
  parameter int NUM_COLUMNS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  kslp_in_t    in_word,
  output logic        empty,
  input  logic        pop,
  output kslp_out_t   out_word,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  localparam int OUT_W = $bits(kslp_out_t);

  logic             cmd_valid;
  kslp_cmd_t        cmd_word;
  logic             cmd_take;
  logic             res_push;
  kslp_out_t        res_word;
  logic             res_full;
  logic [OUT_W-1:0] res_data;

  kslp_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd_word  (cmd_word),
    .cmd_take  (cmd_take)
  );

  kslp_back #(
    .NUM_KEYS    (NUM_KEYS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_word  (cmd_word),
    .cmd_take  (cmd_take),
    .res_push  (res_push),
    .res_word  (res_word),
    .res_full  (res_full)
  );

  kslp_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (4)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_data),
    .empty   (empty)
  );

  assign out_word = kslp_out_t'(res_data);

endmodule

>>> hw/rtl/kslp_fifo.sv
// ----------------------------------------------------------------------------
// kslp_fifo
// Small synchronous first-word-fall-through queue.
// ----------------------------------------------------------------------------
module kslp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/kslp_front.sv
// ----------------------------------------------------------------------------
// kslp_front
// Accepts input words, drops those that do nothing and queues the rest.
// ----------------------------------------------------------------------------
module kslp_front import kslp_pkg::*; #(
  parameter int NUM_KEYS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  kslp_in_t  in_word,
  output logic      cmd_valid,
  output kslp_cmd_t cmd_word,
  input  logic      cmd_take
);

  localparam int CMD_W = $bits(kslp_cmd_t);

  kslp_cmd_t        dec;
  logic             keep;
  logic             key_ok;
  logic [CMD_W-1:0] q_data;
  logic             q_empty;

  assign key_ok = (int'(in_word.key_index) < NUM_KEYS);

  always_comb begin
    dec.key = in_word.key_index;
    dec.op  = OP_TICK;
    keep    = 1'b0;
    case (in_word.command)
      CMD_TICK: begin
        keep = 1'b1;
      end
      CMD_PRESS: begin
        dec.op = OP_PRESS;
        keep   = key_ok;
      end
      CMD_RELEASE: begin
        dec.op = OP_RELEASE;
        keep   = key_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  kslp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full && keep),
    .wr_data (dec),
    .full    (full),
    .rd_en   (cmd_take),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd_word  = kslp_cmd_t'(q_data);

endmodule

>>> hw/rtl/kslp_back.sv
// ----------------------------------------------------------------------------
// kslp_back
// Carries out queued commands: timer, start-time memory, key scan.
// ----------------------------------------------------------------------------
module kslp_back import kslp_pkg::*; #(
  parameter int NUM_KEYS    = 16,
  parameter int NUM_COLUMNS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        cmd_valid,
  input  kslp_cmd_t   cmd_word,
  output logic        cmd_take,
  output logic        res_push,
  output kslp_out_t   res_word,
  input  logic        res_full
);

  localparam int IDX_W = $clog2(NUM_KEYS);
  localparam int SCN_W = IDX_W + 1;
  localparam int HIT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REL,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t               state;
  logic [31:0]          time_now;
  logic [15:0]          long_press_ms;
  logic [NUM_KEYS-1:0]  held;
  logic [NUM_KEYS-1:0]  written;
  logic [31:0]          start_mem [NUM_KEYS];
  logic [31:0]          rd_data;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_valid;
  logic [SCN_W-1:0]     scan_cnt;
  logic [HIT_W-1:0]     hit_cnt;
  logic                 pend_valid;
  logic [IDX_W-1:0]     pend_idx;

  logic [1:0]           row_tbl [NUM_KEYS];
  logic [1:0]           col_tbl [NUM_KEYS];

  logic [IDX_W-1:0]     cmd_idx;
  logic [IDX_W-1:0]     rd_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [31:0]          start_time;
  logic [31:0]          elapsed;
  logic                 is_long;
  logic                 is_short;
  logic                 issue_more;
  logic                 hit;
  logic                 advance;
  logic                 res_want;
  logic [IDX_W-1:0]     res_idx;

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_tbl
    assign row_tbl[g] = 2'((g / NUM_COLUMNS) % 4);
    assign col_tbl[g] = 2'((g % NUM_COLUMNS) % 4);
  end

  assign cmd_idx    = IDX_W'(cmd_word.key);
  // a start time never written reads as zero
  assign start_time = written[rd_idx] ? rd_data : 32'd0;
  assign elapsed    = time_now - start_time;
  assign is_long    = (elapsed >= {16'd0, long_press_ms});
  assign is_short   = (elapsed < {17'd0, long_press_ms[15:1]});

  assign issue_more = (scan_cnt < SCN_W'(NUM_KEYS)) && (hit_cnt < HIT_W'(MAX_RESULTS));
  assign hit        = (state == ST_SCAN) && rd_valid && held[rd_idx] && is_long
                      && (hit_cnt < HIT_W'(MAX_RESULTS));
  // a new hit pushes out the one held back, whose last flag is now known
  assign advance    = !(hit && pend_valid && res_full);

  always_comb begin
    res_want = 1'b0;
    res_idx  = pend_idx;
    res_word = '0;
    case (state)
      ST_REL: begin
        res_want             = is_short;
        res_idx              = rd_idx;
        res_word.press_kind  = KIND_SHORT;
        res_word.last_of_run = 1'b1;
      end
      ST_SCAN: begin
        res_want             = hit && pend_valid;
        res_word.press_kind  = KIND_LONG;
        res_word.last_of_run = 1'b0;
      end
      ST_FLUSH: begin
        res_want             = pend_valid;
        res_word.press_kind  = KIND_LONG;
        res_word.last_of_run = 1'b1;
      end
      default: begin
        res_want = 1'b0;
      end
    endcase
    res_word.column = col_tbl[res_idx];
    res_word.row    = row_tbl[res_idx];
  end

  assign res_push = res_want && !res_full;
  assign cmd_take = (state == ST_IDLE) && cmd_valid;

  assign wr_en   = cmd_take && (cmd_word.op == OP_PRESS);
  assign rd_en   = (cmd_take && (cmd_word.op == OP_RELEASE))
                   || ((state == ST_SCAN) && advance && issue_more);
  assign rd_addr = (state == ST_IDLE) ? cmd_idx : scan_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[cmd_idx] <= time_now;
    end
    if (rd_en) begin
      rd_data <= start_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      time_now      <= '0;
      long_press_ms <= LONG_PRESS_RESET;
      held          <= '0;
      written       <= '0;
      rd_idx        <= '0;
      rd_valid      <= 1'b0;
      scan_cnt      <= '0;
      hit_cnt       <= '0;
      pend_valid    <= 1'b0;
      pend_idx      <= '0;
    end else begin
      if (cfg_write) begin
        long_press_ms <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd_word.op)
              OP_TICK: begin
                time_now   <= time_now + 32'd1;
                scan_cnt   <= '0;
                hit_cnt    <= '0;
                pend_valid <= 1'b0;
                rd_valid   <= 1'b0;
                state      <= ST_SCAN;
              end
              OP_PRESS: begin
                held[cmd_idx]    <= 1'b1;
                written[cmd_idx] <= 1'b1;
              end
              OP_RELEASE: begin
                held[cmd_idx] <= 1'b0;
                rd_idx        <= cmd_idx;
                state         <= ST_REL;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_REL: begin
          if (!is_short || !res_full) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (advance) begin
            if (hit) begin
              held[rd_idx] <= 1'b0;
              pend_valid   <= 1'b1;
              pend_idx     <= rd_idx;
              hit_cnt      <= hit_cnt + 1'b1;
            end
            if (issue_more) begin
              rd_idx   <= scan_cnt[IDX_W-1:0];
              rd_valid <= 1'b1;
              scan_cnt <= scan_cnt + 1'b1;
            end else begin
              rd_valid <= 1'b0;
              if (!rd_valid) begin
                state <= ST_FLUSH;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid || !res_full) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/kslp_checker.sv
// ----------------------------------------------------------------------------
// kslp_checker
// Port-level checks of the press classifier, bound to the top level.
// ----------------------------------------------------------------------------
module kslp_checker import kslp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input kslp_out_t   out_word
);

  // nothing left queued after reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_room_after_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("input queue full after reset");

  // a release gives at most one word, so a short press always closes its run
  a_short_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_word.press_kind == KIND_SHORT) |-> out_word.last_of_run)
    else $error("short press word without last flag");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting result word changed or vanished");

endmodule

bind key_short_long_press_classifier kslp_checker u_kslp_checker (.*);
